// ===== rtl/core/disparity_occlusion_run_fill_defines.svh =====
// Assertion macros shared by the occlusion run fill RTL.
`ifndef DISPARITY_OCCLUSION_RUN_FILL_DEFINES_SVH
`define DISPARITY_OCCLUSION_RUN_FILL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DORF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DORF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dorf_pkg.sv =====
// Package: widths, register codes and result types of the occlusion run fill.
`default_nettype none
package dorf_pkg;

    localparam int MAX_ROW_WIDTH = 4096;

    localparam int PIX_W = 8;
    localparam int ROW_W = 13;
    localparam int CNT_W = 13;
    localparam int COL_W = $clog2(MAX_ROW_WIDTH);
    localparam int CMP_W = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;
    localparam int NRES_W = 2;

    localparam logic [CMP_W-1:0] MAX_WIDTH_C = CMP_W'(MAX_ROW_WIDTH);

    localparam logic [PIX_W-1:0] FILL_LEFT_EDGE = 8'd255;
    localparam logic [PIX_W-1:0] THR_RESET = 8'd10;
    localparam logic [ROW_W-1:0] ROW_RESET = 13'd640;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [NRES_W-1:0] n;
        result_t           r0;
        result_t           r1;
    } fill_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/dorf_if.sv =====
// Stream interfaces: pixel items in, run-length result items out.
`default_nettype none
interface dorf_pix_if;
    logic                      valid;
    logic                      ready;
    logic [dorf_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface dorf_res_if;
    logic                      valid;
    logic                      ready;
    logic [dorf_pkg::PIX_W-1:0] out_value;
    logic [dorf_pkg::CNT_W-1:0] repeat_count;
    logic                      last_of_run;

    modport source (output valid, output out_value, output repeat_count,
                    output last_of_run, input ready);
    modport sink (input valid, input out_value, input repeat_count,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dorf_fill.sv =====
// Run tracking state and per-pixel fill decision.
`default_nettype none
`include "disparity_occlusion_run_fill_defines.svh"
module dorf_fill
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic [dorf_pkg::PIX_W-1:0]     pix,
    input  wire logic [dorf_pkg::PIX_W-1:0]     thr,
    input  wire logic [dorf_pkg::ROW_W-1:0]     row_width,
    output dorf_pkg::fill_res_t                 res
);

    logic [dorf_pkg::COL_W-1:0] col_reg, col_next;
    logic                       open_reg, open_next;
    logic [dorf_pkg::CNT_W-1:0] len_reg, len_next;
    logic [dorf_pkg::PIX_W-1:0] left_reg, left_next;
    logic [dorf_pkg::PIX_W-1:0] prev_reg;

    logic [dorf_pkg::CMP_W-1:0] width_eff;
    logic [dorf_pkg::CMP_W-1:0] row_ext;
    logic                       last;
    logic                       occ;
    logic [dorf_pkg::PIX_W-1:0] edge_left;
    logic [dorf_pkg::PIX_W-1:0] fill;

    always_comb
    begin
        row_ext = dorf_pkg::CMP_W'(row_width);
        if (row_width == '0)
        begin
            width_eff = dorf_pkg::CMP_W'(1);
        end
        else if (row_ext > dorf_pkg::MAX_WIDTH_C)
        begin
            width_eff = dorf_pkg::MAX_WIDTH_C;
        end
        else
        begin
            width_eff = row_ext;
        end
    end

    assign last = (dorf_pkg::CMP_W'(col_reg) + dorf_pkg::CMP_W'(1)) >= width_eff;
    assign occ = pix <= thr;
    assign edge_left = (col_reg != '0) ? prev_reg : dorf_pkg::FILL_LEFT_EDGE;
    assign fill = (!last && pix < left_reg) ? pix : left_reg;

    always_comb
    begin
        res = '0;
        open_next = open_reg;
        len_next = len_reg;
        left_next = left_reg;
        priority if (open_reg && !occ)
        begin
            res.n = 2'd2;
            res.r0 = '{value: fill, count: len_reg, last: 1'b0};
            res.r1 = '{value: pix, count: dorf_pkg::CNT_W'(1), last: 1'b1};
            open_next = 1'b0;
            len_next = '0;
        end
        else if (open_reg && last)
        begin
            res.n = 2'd1;
            res.r0 = '{value: left_reg, count: len_reg + dorf_pkg::CNT_W'(1), last: 1'b1};
            open_next = 1'b0;
            len_next = '0;
        end
        else if (open_reg)
        begin
            len_next = len_reg + dorf_pkg::CNT_W'(1);
        end
        else if (!occ)
        begin
            res.n = 2'd1;
            res.r0 = '{value: pix, count: dorf_pkg::CNT_W'(1), last: 1'b1};
        end
        else if (last)
        begin
            res.n = 2'd1;
            res.r0 = '{value: edge_left, count: dorf_pkg::CNT_W'(1), last: 1'b1};
        end
        else
        begin
            left_next = edge_left;
            len_next = dorf_pkg::CNT_W'(1);
            open_next = 1'b1;
        end
        col_next = last ? '0 : col_reg + dorf_pkg::COL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            open_reg <= 1'b0;
            len_reg <= '0;
            left_reg <= dorf_pkg::FILL_LEFT_EDGE;
            prev_reg <= dorf_pkg::FILL_LEFT_EDGE;
        end
        else if (adv)
        begin
            col_reg <= col_next;
            open_reg <= open_next;
            len_reg <= len_next;
            left_reg <= left_next;
            prev_reg <= pix;
        end
    end

    `DORF_ASSERT_IMPL(a_open_has_len, open_reg, len_reg != '0, "open run with zero length")
    `DORF_ASSERT_IMPL(a_closed_no_len, !open_reg, len_reg == '0, "closed run keeps a length")
    `DORF_ASSERT_NEXT(a_row_wrap, adv && last, col_reg == '0, "column did not wrap at row end")

endmodule
`default_nettype wire

// ===== rtl/core/disparity_occlusion_run_fill.sv =====
// Top level: config registers, input stage, result buffer and fill logic.
// Occluded run fill for a row-major disparity stream. Pixels enter one per
// cycle while the input register is free to take them; the fill decision is
// made between that register and a two-entry result buffer. The output port
// drains one result per cycle while ready is high. A pixel that closes a run
// gives two results (run fill plus the pixel itself), and the input register
// holds its pixel until the buffer has room. Config writes take effect on the
// next pixel.
`default_nettype none
`include "disparity_occlusion_run_fill_defines.svh"
module disparity_occlusion_run_fill
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    dorf_pix_if.sink                                pixels,
    dorf_res_if.source                              runs,
    input  wire logic                               cfg_we,
    input  wire logic [dorf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dorf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [dorf_pkg::PIX_W-1:0] thr_reg;
    logic [dorf_pkg::ROW_W-1:0] row_reg;

    logic                       s1_valid_reg, s1_valid_next;
    logic [dorf_pkg::PIX_W-1:0] pix_reg;

    dorf_pkg::result_t          e0_reg, e0_next;
    dorf_pkg::result_t          e1_reg, e1_next;
    logic [dorf_pkg::NRES_W-1:0] cnt_reg, cnt_next;

    dorf_pkg::fill_res_t        fres;
    logic                       pop;
    logic                       s1_adv;
    logic                       take;

    assign pop = (cnt_reg != '0) && runs.ready;
    assign s1_adv = s1_valid_reg && ((cnt_reg == '0) || (cnt_reg == 2'd1 && runs.ready));
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign take = pixels.valid && pixels.ready;

    assign runs.valid = cnt_reg != '0;
    assign runs.out_value = e0_reg.value;
    assign runs.repeat_count = e0_reg.count;
    assign runs.last_of_run = e0_reg.last;

    dorf_fill u_fill
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (s1_adv),
        .pix       (pix_reg),
        .thr       (thr_reg),
        .row_width (row_reg),
        .res       (fres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= dorf_pkg::THR_RESET;
            row_reg <= dorf_pkg::ROW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dorf_pkg::REG_OCC_THRESHOLD: thr_reg <= cfg_data[dorf_pkg::PIX_W-1:0];
                dorf_pkg::REG_ROW_WIDTH:     row_reg <= cfg_data[dorf_pkg::ROW_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        cnt_next = cnt_reg;
        e0_next = e0_reg;
        e1_next = e1_reg;
        priority if (s1_adv)
        begin
            cnt_next = fres.n;
            e0_next = fres.r0;
            e1_next = fres.r1;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            e0_next = e1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg <= pixels.pixel_value;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    `DORF_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_reg <= 2'd2, "result buffer overfilled")
    `DORF_ASSERT_IMPL(a_pair_order, cnt_reg == 2'd2, !e0_reg.last && e1_reg.last,
        "pair of results out of order")
    `DORF_ASSERT_IMPL(a_adv_room, s1_adv, cnt_reg == '0 || (cnt_reg == 2'd1 && pop),
        "pixel processed without buffer room")
    `DORF_ASSERT_IMPL(a_nonzero_count, runs.valid, runs.repeat_count != '0,
        "result with zero repeat count")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the occlusion run fill: directed rows, register limits, stall, random rows.
module testbench;

    localparam int LONG_HOLD = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [dorf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dorf_pkg::CFG_DATA_W-1:0] cfg_data;

    dorf_pix_if pix_bus();
    dorf_res_if run_bus();

    disparity_occlusion_run_fill DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_bus),
        .runs      (run_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // fill predictor: configuration and row state
    logic [dorf_pkg::PIX_W-1:0] thr_q;
    logic [dorf_pkg::ROW_W-1:0] width_q;
    int unsigned col_q;
    bit run_q;
    int unsigned run_len_q;
    logic [dorf_pkg::PIX_W-1:0] left_q;
    logic [dorf_pkg::PIX_W-1:0] prev_q;

    dorf_pkg::result_t fill_queue[$];
    int errors;
    int pixels_in;
    int results_out;
    bit idle_en;
    bit hold_req;

    function automatic dorf_pkg::result_t make_result(input logic [dorf_pkg::PIX_W-1:0] value,
                                                      input int unsigned count, input bit fin);
        dorf_pkg::result_t r;
        r.value = value;
        r.count = dorf_pkg::CNT_W'(count);
        r.last = fin;
        return r;
    endfunction

    function automatic void add_expected(input logic [dorf_pkg::PIX_W-1:0] value,
                                         input int unsigned count, input bit fin);
        fill_queue.insert(fill_queue.size(), make_result(value, count, fin));
    endfunction

    task automatic predict_fill(input logic [dorf_pkg::PIX_W-1:0] v);
        int unsigned w;
        bit last;
        bit occ;
        logic [dorf_pkg::PIX_W-1:0] edge_val;
        logic [dorf_pkg::PIX_W-1:0] fill;
        w = (width_q == 0) ? 1 : ((width_q > dorf_pkg::MAX_ROW_WIDTH) ?
                                  dorf_pkg::MAX_ROW_WIDTH : width_q);
        last = (col_q + 1 >= w);
        occ = (v <= thr_q);
        edge_val = (col_q > 0) ? prev_q : dorf_pkg::FILL_LEFT_EDGE;
        if (run_q)
        begin
            if (!occ)
            begin
                fill = (!last && v < left_q) ? v : left_q;
                add_expected(fill, run_len_q, 1'b0);
                add_expected(v, 1, 1'b1);
                run_q = 1'b0;
                run_len_q = 0;
            end
            else if (last)
            begin
                add_expected(left_q, run_len_q + 1, 1'b1);
                run_q = 1'b0;
                run_len_q = 0;
            end
            else
                run_len_q++;
        end
        else
        begin
            if (!occ)
                add_expected(v, 1, 1'b1);
            else if (last)
                add_expected(edge_val, 1, 1'b1);
            else
            begin
                left_q = edge_val;
                run_len_q = 1;
                run_q = 1'b1;
            end
        end
        prev_q = v;
        col_q = last ? 0 : col_q + 1;
    endtask

    always @(posedge clk)
    begin : monitor
        dorf_pkg::result_t want;
        dorf_pkg::result_t got;
        if (rst_n)
        begin
            if (run_bus.valid && run_bus.ready)
            begin
                results_out++;
                got = make_result(run_bus.out_value, 32'(run_bus.repeat_count),
                                  run_bus.last_of_run);
                if (fill_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result value %0d count %0d last %0b",
                             $time, got.value, got.count, got.last);
                end
                else
                begin
                    want = fill_queue.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display({"%0t: mismatch expected value %0d count %0d last %0b,",
                                  " actual value %0d count %0d last %0b"},
                                 $time, want.value, want.count, want.last,
                                 got.value, got.count, got.last);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    dorf_pkg::REG_OCC_THRESHOLD: thr_q = cfg_data[dorf_pkg::PIX_W-1:0];
                    dorf_pkg::REG_ROW_WIDTH:     width_q = cfg_data[dorf_pkg::ROW_W-1:0];
                    default: ;
                endcase
            end
            if (pix_bus.valid && pix_bus.ready)
            begin
                pixels_in++;
                predict_fill(pix_bus.pixel_value);
            end
        end
    end

    initial
    begin : result_sink
        int n;
        run_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                run_bus.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                run_bus.ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n - 1) @(posedge clk);
            end
            else
                run_bus.ready <= 1'b1;
        end
    end

    task automatic send_pixel(input logic [dorf_pkg::PIX_W-1:0] v);
        pix_bus.valid <= 1'b1;
        pix_bus.pixel_value <= v;
        do @(posedge clk); while (!pix_bus.ready);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        @(posedge clk);
        while (fill_queue.size() != 0) @(posedge clk);
        // a pixel that only extends a run may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dorf_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= dorf_pkg::CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned thr, input int unsigned width);
        drain_results();
        write_reg(dorf_pkg::REG_OCC_THRESHOLD, thr);
        write_reg(dorf_pkg::REG_ROW_WIDTH, width);
    endtask

    function automatic logic [dorf_pkg::PIX_W-1:0] occluded_pixel();
        return dorf_pkg::PIX_W'($urandom_range(0, thr_q));
    endfunction

    function automatic logic [dorf_pkg::PIX_W-1:0] clear_pixel();
        if (thr_q == 8'hFF)
            return 8'hFF;
        return dorf_pkg::PIX_W'($urandom_range(thr_q + 1, 255));
    endfunction

    task automatic test_directed_rows();
        logic [dorf_pkg::PIX_W-1:0] rows[20];
        rows = '{8'd3, 8'd3, 8'd3, 8'd200,
                 8'd100, 8'd3, 8'd3, 8'd50,
                 8'd100, 8'd3, 8'd3, 8'd3,
                 8'd100, 8'd255, 8'd200, 8'd3,
                 8'd11, 8'd10, 8'd0, 8'd255};
        // a few pixels at reset settings, then four-wide rows
        send_pixel(8'd0);
        send_pixel(8'd120);
        set_config(10, 4);
        write_reg(dorf_pkg::REG_ROW_WIDTH, 0);
        write_reg(dorf_pkg::REG_ROW_WIDTH, 4);
        send_pixel(8'd3);
        send_pixel(8'd250);
        foreach (rows[i])
            send_pixel(rows[i]);
        // zero width acts as one pixel per row
        set_config(10, 0);
        send_pixel(8'd3);
        send_pixel(8'd200);
    endtask

    task automatic test_register_extremes();
        set_config(0, 3);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd0);
        // saturated width, long open run, then width cut below the column
        set_config(255, 8191);
        repeat (12) send_pixel(dorf_pkg::PIX_W'($urandom_range(0, 255)));
        set_config(10, 5);
        send_pixel(8'd200);
        set_config(128, 4096);
        repeat (6) send_pixel(dorf_pkg::PIX_W'($urandom_range(0, 255)));
        set_config(128, 2);
        send_pixel(8'd7);
    endtask

    task automatic test_output_stall();
        set_config(50, 7);
        idle_en = 1'b0;
        hold_req = 1'b1;
        repeat (40)
        begin
            if ($urandom_range(0, 1) == 0)
                send_pixel(occluded_pixel());
            else
                send_pixel(clear_pixel());
        end
        idle_en = 1'b1;
        drain_results();
    endtask

    task automatic send_random_rows(input int count);
        int sent;
        int run;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_pixel(dorf_pkg::PIX_W'($urandom_range(0, 255)));
                    sent++;
                end
                1, 2, 3, 4:
                begin
                    run = $urandom_range(1, 6);
                    repeat (run) send_pixel(occluded_pixel());
                    sent += run;
                end
                default:
                begin
                    send_pixel(clear_pixel());
                    sent++;
                end
            endcase
        end
    endtask

    task automatic test_random_rows();
        int unsigned thr;
        int unsigned width;
        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 5))
                0: thr = 0;
                1: thr = 255;
                2: thr = 10;
                default: thr = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 9))
                0: width = 0;
                1: width = 640;
                2: width = 8191;
                default: width = $urandom_range(1, 16);
            endcase
            set_config(thr, width);
            if (phase == 5)
                idle_en = 1'b0;
            send_random_rows(100);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        pix_bus.valid <= 1'b0;
        pix_bus.pixel_value <= '0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        errors = 0;
        pixels_in = 0;
        results_out = 0;
        thr_q = dorf_pkg::THR_RESET;
        width_q = dorf_pkg::ROW_RESET;
        col_q = 0;
        run_q = 1'b0;
        run_len_q = 0;
        left_q = dorf_pkg::FILL_LEFT_EDGE;
        prev_q = dorf_pkg::FILL_LEFT_EDGE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_rows();
        test_register_extremes();
        test_output_stall();
        test_random_rows();

        drain_results();
        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d pixels: edge and interior runs, width limits,",
                 results_out, pixels_in);
        $display("a width cut mid-row, a long output stall and random rows over random settings.");
        if (errors == 0)
            $display("disparity_occlusion_run_fill test passed");
        else
            $display("disparity_occlusion_run_fill test failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d results outstanding", fill_queue.size());
        $display("disparity_occlusion_run_fill test failed");
        $finish;
    end

endmodule
